// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/etmm_pkg.sv -----
// ----------------------------------------------------------------------------
// etmm_pkg
// Types, constants and helper functions for the Euler TRS model matrix block.
// ----------------------------------------------------------------------------
package etmm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_FRAC     = 24;
    localparam int TRIG_FRAC    = 30;
    localparam int TABLE_LEN    = 24;
    localparam int STEP_W       = $clog2(TABLE_LEN);
    localparam int ZW           = 36;
    localparam int TW           = 34;

    localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_ROTATE    = 2'd1;
    localparam logic [1:0] CMD_SCALE     = 2'd2;
    localparam logic [1:0] CMD_READ      = 2'd3;

    localparam logic signed [33:0] ANGLE_MOD = 34'sd360 <<< FRAC_BITS;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         column;
        logic signed [31:0] row0_value;
        logic signed [31:0] row1_value;
        logic signed [31:0] row2_value;
        logic               last;
    } t_out_item;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_UPDATE  = 4'd1;
    localparam logic [3:0] OP_CINIT   = 4'd2;
    localparam logic [3:0] OP_CSTEP   = 4'd3;
    localparam logic [3:0] OP_CDONE   = 4'd4;
    localparam logic [3:0] OP_MUL     = 4'd5;
    localparam logic [3:0] OP_EMIT    = 4'd6;

    typedef struct packed {
        logic [3:0]        op;
        logic [1:0]        axis;
        logic [STEP_W-1:0] step;
        logic [4:0]        mul_idx;
        logic [1:0]        column;
    } t_cmd;

    function automatic logic signed [ZW-1:0] atan_deg(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 36'sd754974720;
            5'd1:    v = 36'sd445687602;
            5'd2:    v = 36'sd235489089;
            5'd3:    v = 36'sd119537938;
            5'd4:    v = 36'sd60000934;
            5'd5:    v = 36'sd30029717;
            5'd6:    v = 36'sd15018523;
            5'd7:    v = 36'sd7509720;
            5'd8:    v = 36'sd3754917;
            5'd9:    v = 36'sd1877466;
            5'd10:   v = 36'sd938734;
            5'd11:   v = 36'sd469367;
            5'd12:   v = 36'sd234684;
            5'd13:   v = 36'sd117342;
            5'd14:   v = 36'sd58671;
            5'd15:   v = 36'sd29335;
            5'd16:   v = 36'sd14668;
            5'd17:   v = 36'sd7334;
            5'd18:   v = 36'sd3667;
            5'd19:   v = 36'sd1833;
            5'd20:   v = 36'sd917;
            5'd21:   v = 36'sd458;
            5'd22:   v = 36'sd229;
            5'd23:   v = 36'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- src/etmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// etmm_ctrl
// Sequencer: issues updates, CORDIC iterations, multiplies and column output.
// ----------------------------------------------------------------------------
module etmm_ctrl import etmm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_command,
    input  logic       i_out_busy,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CINIT = 3'd1;
    localparam logic [2:0] S_CSTEP = 3'd2;
    localparam logic [2:0] S_CDONE = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [4:0] MUL_LAST = 5'd22;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_axis, n_axis;
    logic [STEP_W-1:0] r_step, n_step;
    logic [4:0]        r_mul, n_mul;
    logic [1:0]        r_col, n_col;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_step  = r_step;
        n_mul   = r_mul;
        n_col   = r_col;
        o_in_ready = 1'b0;
        o_cmd = '{op: OP_NONE, axis: r_axis, step: r_step, mul_idx: r_mul, column: r_col};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_command == CMD_READ) begin
                        n_state = S_CINIT;
                        n_axis  = 2'd0;
                    end else begin
                        o_cmd.op = OP_UPDATE;
                    end
                end
            end
            S_CINIT: begin
                o_cmd.op = OP_CINIT;
                n_step  = '0;
                n_state = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.op = OP_CSTEP;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_CDONE;
                end
            end
            S_CDONE: begin
                o_cmd.op = OP_CDONE;
                if (r_axis == 2'd2) begin
                    n_state = S_MUL;
                    n_mul   = '0;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_CINIT;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_mul = r_mul + 1'b1;
                if (r_mul == MUL_LAST) begin
                    n_state = S_EMIT;
                    n_col   = 2'd0;
                end
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_col = r_col + 1'b1;
                    if (r_col == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_step  <= '0;
            r_mul   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_step  <= n_step;
            r_mul   <= n_mul;
            r_col   <= n_col;
        end
    end

endmodule

// ----- src/etmm_dp.sv -----
// ----------------------------------------------------------------------------
// etmm_dp
// Datapath: state registers, shared CORDIC unit, two shared multipliers, output.
// ----------------------------------------------------------------------------
module etmm_dp import etmm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic      i_out_ready,
    output logic      o_out_busy,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic signed [31:0]   r_pos [3];
    logic signed [31:0]   r_ang [3];
    logic signed [31:0]   r_scl [3];
    logic signed [TW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic                 r_neg;
    logic signed [TW-1:0] r_cos [3];
    logic signed [TW-1:0] r_sin [3];
    // Products: 0 sysx, 1 sycx, 2..13 rotation terms; then 9 scaled elements.
    logic signed [TW-1:0] r_t [14];
    logic signed [31:0]   r_e [9];
    logic                 r_ov;
    t_out_item            r_oi;

    logic signed [31:0]   d [3];
    logic signed [TW-1:0] rel [9];

    logic signed [TW-1:0] ma, mb;
    logic [4:0]           mi;
    logic signed [67:0]   prod;
    logic signed [67:0]   rsum;
    logic signed [37:0]   rsh;

    logic signed [TW-1:0] sel_r;
    logic signed [31:0]   sel_s;
    logic signed [65:0]   sprod;
    logic signed [35:0]   ssh;
    logic [3:0]           eidx;

    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] zfull, zhalf, zquar;
    logic signed [ZW-1:0] zr;
    logic                 nr;

    logic signed [TW-1:0] xs, ys;

    logic signed [33:0]   usum [3];
    logic signed [33:0]   asum [3];
    logic signed [33:0]   awrap [3];

    // Angle wrap: a 32-bit delta spans many turns, so reduce via a constant
    // reciprocal multiply and correction.
    function automatic logic signed [33:0] wrap360(input logic signed [33:0] v);
        logic        s;
        logic [33:0] mag;
        logic [67:0] q;
        logic [33:0] qq;
        logic [33:0] rem;
        s   = v[33];
        mag = s ? 34'(-v) : v;
        // floor(mag / (360 << 16)) via reciprocal of 360, then shift.
        q   = 68'(mag >> FRAC_BITS) * 68'd11930465;
        qq  = 34'(q >> 32);
        rem = mag - 34'(qq * 34'(ANGLE_MOD));
        if (rem >= 34'(ANGLE_MOD)) begin
            rem = rem - 34'(ANGLE_MOD);
        end
        if (s && rem != 0) begin
            rem = 34'(ANGLE_MOD) - rem;
        end
        return rem;
    endfunction

    assign d[0] = i_item.delta_x;
    assign d[1] = i_item.delta_y;
    assign d[2] = i_item.delta_z;

    // Rotation elements of Rz*Ry*Rx, column-major.
    always_comb begin
        rel[0] = r_t[2];
        rel[1] = r_t[3];
        rel[2] = -r_sin[1];
        rel[3] = r_t[5] - r_t[4];
        rel[4] = r_t[6] + r_t[7];
        rel[5] = r_t[8];
        rel[6] = r_t[9] + r_t[10];
        rel[7] = r_t[12] - r_t[11];
        rel[8] = r_t[13];
    end

    always_comb begin
        mi = i_cmd.mul_idx;
        ma = '0;
        mb = '0;
        case (mi)
            5'd0:  begin ma = r_sin[1]; mb = r_sin[0]; end
            5'd1:  begin ma = r_sin[1]; mb = r_cos[0]; end
            5'd2:  begin ma = r_cos[2]; mb = r_cos[1]; end
            5'd3:  begin ma = r_sin[2]; mb = r_cos[1]; end
            5'd4:  begin ma = r_sin[2]; mb = r_cos[0]; end
            5'd5:  begin ma = r_cos[2]; mb = r_t[0];   end
            5'd6:  begin ma = r_cos[2]; mb = r_cos[0]; end
            5'd7:  begin ma = r_sin[2]; mb = r_t[0];   end
            5'd8:  begin ma = r_cos[1]; mb = r_sin[0]; end
            5'd9:  begin ma = r_sin[2]; mb = r_sin[0]; end
            5'd10: begin ma = r_cos[2]; mb = r_t[1];   end
            5'd11: begin ma = r_cos[2]; mb = r_sin[0]; end
            5'd12: begin ma = r_sin[2]; mb = r_t[1];   end
            5'd13: begin ma = r_cos[1]; mb = r_cos[0]; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb;
        rsum = prod + (68'sd1 <<< (TRIG_FRAC - 1));
        rsh  = 38'(rsum >>> TRIG_FRAC);
    end

    // Element and scale selection for the scaling multiplies.
    always_comb begin
        eidx  = 4'(mi - 5'd14);
        sel_r = '0;
        sel_s = r_scl[0];
        case (eidx)
            4'd0: begin sel_r = rel[0]; sel_s = r_scl[0]; end
            4'd1: begin sel_r = rel[1]; sel_s = r_scl[0]; end
            4'd2: begin sel_r = rel[2]; sel_s = r_scl[0]; end
            4'd3: begin sel_r = rel[3]; sel_s = r_scl[1]; end
            4'd4: begin sel_r = rel[4]; sel_s = r_scl[1]; end
            4'd5: begin sel_r = rel[5]; sel_s = r_scl[1]; end
            4'd6: begin sel_r = rel[6]; sel_s = r_scl[2]; end
            4'd7: begin sel_r = rel[7]; sel_s = r_scl[2]; end
            4'd8: begin sel_r = rel[8]; sel_s = r_scl[2]; end
            default: begin sel_r = '0; sel_s = r_scl[0]; end
        endcase
        sprod = sel_r * sel_s;
        ssh   = 36'((sprod + (66'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC);
    end

    // CORDIC datapath for the current axis.
    assign zfull = ZW'(360) <<< ANG_FRAC;
    assign zhalf = ZW'(180) <<< ANG_FRAC;
    assign zquar = ZW'(90)  <<< ANG_FRAC;
    always_comb begin
        z0 = ZW'(r_ang[i_cmd.axis]) <<< (ANG_FRAC - FRAC_BITS);
        if (z0 > zhalf) begin
            z0 = z0 - zfull;
        end
        nr = 1'b0;
        zr = z0;
        if (z0 > zquar) begin
            zr = z0 - zhalf;
            nr = 1'b1;
        end else if (z0 < -zquar) begin
            zr = z0 + zhalf;
            nr = 1'b1;
        end
    end

    assign xs = r_cx >>> i_cmd.step;
    assign ys = r_cy >>> i_cmd.step;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            usum[k]  = 34'(i_item.command == CMD_TRANSLATE ? r_pos[k] : r_scl[k]) + 34'(d[k]);
            asum[k]  = 34'(r_ang[k]) + 34'(d[k]);
            awrap[k] = wrap360(asum[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_ang[k] <= '0;
                r_scl[k] <= 32'sd1 <<< FRAC_BITS;
            end
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.op == OP_UPDATE) begin
                for (int k = 0; k < 3; k++) begin
                    case (i_item.command)
                        CMD_TRANSLATE: r_pos[k] <= sat32(usum[k]);
                        CMD_ROTATE:    r_ang[k] <= awrap[k][31:0];
                        CMD_SCALE:     r_scl[k] <= sat32(usum[k]);
                        default:       ;
                    endcase
                end
            end
            if (i_cmd.op == OP_EMIT) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CINIT: begin
                r_cx  <= CORDIC_GAIN;
                r_cy  <= '0;
                r_cz  <= zr;
                r_neg <= nr;
            end
            OP_CSTEP: begin
                if (r_cz >= 0) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_deg(i_cmd.step);
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_deg(i_cmd.step);
                end
            end
            OP_CDONE: begin
                r_cos[i_cmd.axis] <= r_neg ? -r_cx : r_cx;
                r_sin[i_cmd.axis] <= r_neg ? -r_cy : r_cy;
            end
            OP_MUL: begin
                if (mi < 5'd14) begin
                    r_t[mi[3:0]] <= TW'(rsh);
                end else begin
                    r_e[eidx] <= sat32(34'(ssh > 36'sd8589934591 ? 36'sd8589934591 :
                                 (ssh < -36'sd8589934592 ? -36'sd8589934592 : ssh)));
                end
            end
            OP_EMIT: begin
                r_oi.column <= i_cmd.column;
                r_oi.last   <= (i_cmd.column == 2'd3);
                if (i_cmd.column == 2'd3) begin
                    r_oi.row0_value <= r_pos[0];
                    r_oi.row1_value <= r_pos[1];
                    r_oi.row2_value <= r_pos[2];
                end else begin
                    r_oi.row0_value <= r_e[4'(i_cmd.column) * 4'd3];
                    r_oi.row1_value <= r_e[4'(i_cmd.column) * 4'd3 + 4'd1];
                    r_oi.row2_value <= r_e[4'(i_cmd.column) * 4'd3 + 4'd2];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_busy  = r_ov && !i_out_ready;
    assign o_out_item  = r_oi;

endmodule

// ----- src/euler_trs_model_matrix.sv -----
// Operation: an update takes effect at its transfer; a read runs the shared CORDIC unit
// for each of the three axes, then 23 multiplies on the shared multipliers, then four columns.
// Flow: one update per cycle while idle; a new command is taken only once the last column
// of a read has been issued to the output, so sink back-pressure also holds the input.
// Reset: synchronous, active low; position 0, angles 0, scale 1.0.
// ----------------------------------------------------------------------------
// euler_trs_model_matrix
// Top level: TRS model matrix from Euler angles, controller plus datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_trs_model_matrix import etmm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd cmd;
    logic out_busy;
    logic last_ok;

    etmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_item.command),
        .i_out_busy (out_busy),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    etmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_busy  (out_busy),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign last_ok = (o_out_item.last == (o_out_item.column == 2'd3));

    `ASSERT_IMPL(a_last_col3, i_clk, i_rst_n, o_out_valid, last_ok)
    `ASSERT_IMPL(a_no_in_during_out, i_clk, i_rst_n, o_out_valid, !o_in_ready || o_out_item.last)
    `ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.op == OP_EMIT, o_out_valid)

endmodule

// ----- dv/etmm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// etmm_checker
// Watches both channels of the model matrix block, keeps its own copy of the
// position, angle and scale state, predicts the four matrix columns of every
// read and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module etmm_checker import etmm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam longint Q30_HALF = 64'sd1 <<< 29;

    longint    pos_state [3];
    longint    ang_state [3];
    longint    scl_state [3];
    t_out_item column_queue [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint trig_product(input longint a, input longint b);
        return (a * b + Q30_HALF) >>> 30;
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl [24];
        tbl = '{754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
                15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
                117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tbl[i];
    endfunction

    task automatic cos_sin(input longint ang, output longint c, output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = ang <<< (ANG_FRAC - FRAC_BITS);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > (longint'(180) <<< ANG_FRAC)) z -= longint'(360) <<< ANG_FRAC;
        if (z > (longint'(90) <<< ANG_FRAC)) begin
            z -= longint'(180) <<< ANG_FRAC;
            flip = 1;
        end else if (z < -(longint'(90) <<< ANG_FRAC)) begin
            z += longint'(180) <<< ANG_FRAC;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_step(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_columns();
        longint    cx, sx, cy, sy, cz, sz, sysx, sycx;
        longint    rot [3][3];
        t_out_item col;
        cos_sin(ang_state[0], cx, sx);
        cos_sin(ang_state[1], cy, sy);
        cos_sin(ang_state[2], cz, sz);
        sysx = trig_product(sy, sx);
        sycx = trig_product(sy, cx);
        rot[0][0] = trig_product(cz, cy);
        rot[0][1] = trig_product(sz, cy);
        rot[0][2] = -sy;
        rot[1][0] = -trig_product(sz, cx) + trig_product(cz, sysx);
        rot[1][1] = trig_product(cz, cx) + trig_product(sz, sysx);
        rot[1][2] = trig_product(cy, sx);
        rot[2][0] = trig_product(sz, sx) + trig_product(cz, sycx);
        rot[2][1] = -trig_product(cz, sx) + trig_product(sz, sycx);
        rot[2][2] = trig_product(cy, cx);
        for (int c = 0; c < 3; c++) begin
            col.column     = c[1:0];
            col.row0_value = 32'(clamp32(trig_product(rot[c][0], scl_state[c])));
            col.row1_value = 32'(clamp32(trig_product(rot[c][1], scl_state[c])));
            col.row2_value = 32'(clamp32(trig_product(rot[c][2], scl_state[c])));
            col.last       = 1'b0;
            column_queue.push_back(col);
        end
        col.column     = 2'd3;
        col.row0_value = 32'(pos_state[0]);
        col.row1_value = 32'(pos_state[1]);
        col.row2_value = 32'(pos_state[2]);
        col.last       = 1'b1;
        column_queue.push_back(col);
    endtask

    task automatic apply_command(input t_in_item it);
        longint d [3];
        longint r;
        d[0] = $signed(it.delta_x);
        d[1] = $signed(it.delta_y);
        d[2] = $signed(it.delta_z);
        case (it.command)
            CMD_TRANSLATE: begin
                for (int i = 0; i < 3; i++) pos_state[i] = clamp32(pos_state[i] + d[i]);
            end
            CMD_ROTATE: begin
                for (int i = 0; i < 3; i++) begin
                    r = (ang_state[i] + d[i]) % (longint'(360) <<< FRAC_BITS);
                    if (r < 0) r += longint'(360) <<< FRAC_BITS;
                    ang_state[i] = r;
                end
            end
            CMD_SCALE: begin
                for (int i = 0; i < 3; i++) scl_state[i] = clamp32(scl_state[i] + d[i]);
            end
            default: begin
                predict_columns();
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("column mismatch on %s: got %0d, expected %0d", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                pos_state[i] = 0;
                ang_state[i] = 0;
                scl_state[i] = longint'(1) <<< FRAC_BITS;
            end
            column_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_command(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (column_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", i_out_item.column, -1);
                end else begin
                    want = column_queue.pop_front();
                    if (i_out_item.column !== want.column)
                        report_mismatch("column", i_out_item.column, want.column);
                    if (i_out_item.row0_value !== want.row0_value)
                        report_mismatch("row0", i_out_item.row0_value, want.row0_value);
                    if (i_out_item.row1_value !== want.row1_value)
                        report_mismatch("row1", i_out_item.row1_value, want.row1_value);
                    if (i_out_item.row2_value !== want.row2_value)
                        report_mismatch("row2", i_out_item.row2_value, want.row2_value);
                    if (i_out_item.last !== want.last)
                        report_mismatch("last", i_out_item.last, want.last);
                end
            end
        end
        o_pending = column_queue.size();
    end

endmodule

// ----- dv/tb_euler_trs_model_matrix.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_trs_model_matrix
// Drives directed and random translate, rotate, scale and read commands into
// the model matrix block with random idling on both sides and one long sink
// hold-off, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_euler_trs_model_matrix;
    import etmm_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        hold_sink;
    bit        calm;

    euler_trs_model_matrix u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    etmm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("euler_trs_model_matrix: mismatch");
        $finish;
    end

    function automatic logic [31:0] pick_delta(input logic [1:0] cmd);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: begin
                if (cmd == CMD_ROTATE) return 32'($urandom_range(0, 720 << 16)) - (360 << 16);
                return 32'($urandom_range(0, 8 << 16)) - (4 << 16);
            end
        endcase
    endfunction

    task automatic send_command(input logic [1:0] cmd, input logic [31:0] dx,
                                input logic [31:0] dy, input logic [31:0] dz);
        while (!calm && $urandom_range(0, 99) < 29) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, delta_x: dx, delta_y: dy, delta_z: dz};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [1:0] cmd;
        cmd = 2'($urandom_range(0, 3));
        send_command(cmd, pick_delta(cmd), pick_delta(cmd), pick_delta(cmd));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sink) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    initial begin
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        hold_sink = 1'b0;
        calm      = 1'b0;
        i_rst_n   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(CMD_READ, 32'hffffffff, 32'h80000000, 32'h7fffffff);
        send_command(CMD_ROTATE, 32'd90 << 16, 32'd180 << 16, 32'd270 << 16);
        send_command(CMD_READ, '0, '0, '0);
        send_command(CMD_ROTATE, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        send_command(CMD_ROTATE, 32'h80000000, 32'd45 << 16, 32'h00000001);
        send_command(CMD_READ, '0, '0, '0);
        send_command(CMD_TRANSLATE, 32'h7fffffff, 32'h80000000, 32'h12345678);
        send_command(CMD_TRANSLATE, 32'h7fffffff, 32'h80000000, 32'hedcba987);
        send_command(CMD_SCALE, 32'h7fffffff, 32'h80000000, -32'sd65536);
        send_command(CMD_READ, '0, '0, '0);
        send_command(CMD_SCALE, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_command(CMD_READ, '0, '0, '0);
        send_command(CMD_SCALE, 32'h80000000, 32'h80000000, 32'h80000000);
        send_command(CMD_ROTATE, 32'd135 << 16, 32'd300 << 16, 32'd1 << 16);
        send_command(CMD_READ, '0, '0, '0);

        fork
            begin
                hold_sink = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int n = 0; n < 12; n++) begin
                send_command(CMD_READ, $urandom(), $urandom(), $urandom());
            end
        join

        for (int n = 0; n < 203; n++) begin
            calm = (n >= 80 && n < 130);
            send_random();
        end
        calm = 1'b0;
        in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("euler_trs_model_matrix: match");
        end else begin
            $display("euler_trs_model_matrix: mismatch");
        end
        $finish;
    end

endmodule
